[hw/rtl/ghp_pkg.sv]
package ghp_pkg;

  localparam int unsigned GEN_W      = 32;
  localparam int unsigned RC_W       = 16;
  localparam int unsigned HIDX_W     = 8;
  localparam int unsigned SEL_W      = 4;
  localparam int unsigned EV_COUNT   = 8;
  localparam int unsigned EV_W       = $clog2(EV_COUNT);

  localparam logic [GEN_W-1:0] GEN_MAX    = '1;
  localparam logic [RC_W-1:0]  RC_MAX     = '1;
  localparam logic [7:0]       ACTIVE_MAX = 8'hFF;

  // stat read selects
  localparam logic [SEL_W-1:0] STAT_ACTIVE  = 4'd0;
  localparam logic [SEL_W-1:0] STAT_PEAK    = 4'd1;
  localparam logic [SEL_W-1:0] STAT_EV_BASE = 4'd2;
  localparam logic [SEL_W-1:0] STAT_LAST    = 4'd9;

  typedef enum logic [2:0] {
    FN_ACQUIRE   = 3'd0,
    FN_PUBLISH   = 3'd1,
    FN_RETAIN    = 3'd2,
    FN_RESOLVE   = 3'd3,
    FN_RELEASE   = 3'd4,
    FN_RECLAIM   = 3'd5,
    FN_READ_STAT = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    SS_FREE      = 2'd0,
    SS_BUILDING  = 2'd1,
    SS_PUBLISHED = 2'd2
  } slot_state_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_STALE   = 2'd1,
    STS_INVALID = 2'd2,
    STS_FULL    = 2'd3
  } status_e;

  typedef enum logic [EV_W-1:0] {
    EV_ACQUIRE = 3'd0,
    EV_ACQFAIL = 3'd1,
    EV_PUBLISH = 3'd2,
    EV_RETAIN  = 3'd3,
    EV_RELEASE = 3'd4,
    EV_STALE   = 3'd5,
    EV_INVALID = 3'd6,
    EV_RECLAIM = 3'd7
  } ev_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_EXEC
  } fsm_e;

  typedef struct packed {
    logic [2:0]        func;
    logic [GEN_W-1:0]  handle_generation;
    logic [HIDX_W-1:0] handle_index;
    logic [SEL_W-1:0]  stat_select;
  } req_t;

  typedef struct packed {
    logic              success;
    logic [1:0]        status;
    logic [HIDX_W-1:0] slot_index;
    logic [GEN_W-1:0]  slot_generation;
    logic [GEN_W-1:0]  stat_value;
  } res_t;

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [RC_W-1:0]  refcnt;
  } slot_word_t;

endpackage

[hw/rtl/generation_handle_slot_pool.sv]
// Handle, reclaim and stat requests go from accept through EXEC to the registered done strobe;
// acquire first runs SCAN from slot 0 up to the lowest free slot, or the last slot when full.
// One request at a time; busy stays high until the result is registered.
// The acquire free-slot scan walks the slot state one entry per cycle and shares the
// single slot memory read port with handle lookups.
// Reset clears all slot state, counters and valid bits at once; results cannot be stalled.
module generation_handle_slot_pool #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  ghp_pkg::req_t req_i,
  output logic        busy,
  output logic        done_o,
  output ghp_pkg::res_t res_o
);
  import ghp_pkg::*;

  localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(SLOT_COUNT - 1);

  fsm_e             fsm_q, fsm_d;
  func_e            func_q;
  logic [GEN_W-1:0] gen_q;
  logic [SEL_W-1:0] sel_q;
  logic [IW-1:0]    idx_q, idx_d;
  logic             oob_q;
  logic             full_q, full_d;

  slot_state_e      slot_state_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] gen_vld_q;
  slot_word_t       slot_mem [SLOT_COUNT];
  slot_word_t       rd_q;
  logic [IW-1:0]    rd_addr;

  logic [7:0]       active_q, active_d;
  logic [7:0]       peak_q, peak_d;
  logic [GEN_W-1:0] ev_q [EV_COUNT];

  logic             done_q, done_d;
  res_t             res_q, res_d;

  logic             accept;
  logic             wr_en;
  slot_word_t       wr_word;
  logic             st_we;
  slot_state_e      st_wdata;
  logic             ev_en;
  ev_e              ev_sel;

  slot_state_e      cur_st;
  logic [GEN_W-1:0] cur_gen;
  logic [RC_W-1:0]  cur_rc;
  logic [GEN_W-1:0] next_gen;
  logic [RC_W-1:0]  dec_rc;
  logic             stale;
  logic [EV_W-1:0]  stat_ev;

  assign busy   = (fsm_q != FSM_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // never-written entries read as zero
  assign cur_st   = slot_state_q[idx_q];
  assign cur_gen  = gen_vld_q[idx_q] ? rd_q.gen : '0;
  assign cur_rc   = gen_vld_q[idx_q] ? rd_q.refcnt : '0;
  assign next_gen = (cur_gen == GEN_MAX) ? GEN_W'(1) : cur_gen + GEN_W'(1);
  assign dec_rc   = cur_rc - RC_W'(1);
  assign stale    = (gen_q == '0) || oob_q || (cur_st == SS_FREE) ||
                    (cur_gen != gen_q) || (cur_rc == '0);
  assign stat_ev  = EV_W'(sel_q - STAT_EV_BASE);

  always_comb begin
    fsm_d    = fsm_q;
    idx_d    = idx_q;
    full_d   = full_q;
    rd_addr  = idx_q;
    accept   = 1'b0;
    wr_en    = 1'b0;
    wr_word  = '0;
    st_we    = 1'b0;
    st_wdata = SS_FREE;
    active_d = active_q;
    peak_d   = peak_q;
    ev_en    = 1'b0;
    ev_sel   = EV_ACQUIRE;
    done_d   = 1'b0;
    res_d    = res_q;
    unique case (fsm_q)
      FSM_IDLE: begin
        rd_addr = req_i.handle_index[IW-1:0];
        if (start) begin
          accept = 1'b1;
          full_d = 1'b0;
          if (req_i.func == FN_ACQUIRE) begin
            idx_d = '0;
            fsm_d = FSM_SCAN;
          end else begin
            idx_d = req_i.handle_index[IW-1:0];
            fsm_d = FSM_EXEC;
          end
        end
      end
      FSM_SCAN: begin
        // hold idx on a hit so the registered read matches the claimed slot
        priority if (cur_st == SS_FREE) begin
          fsm_d = FSM_EXEC;
        end else if (idx_q == LastIdx) begin
          full_d = 1'b1;
          fsm_d  = FSM_EXEC;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      FSM_EXEC: begin
        fsm_d  = FSM_IDLE;
        done_d = 1'b1;
        res_d  = '0;
        unique case (func_q)
          FN_ACQUIRE: begin
            ev_en = 1'b1;
            if (full_q) begin
              ev_sel       = EV_ACQFAIL;
              res_d.status = STS_FULL;
            end else begin
              ev_sel          = EV_ACQUIRE;
              wr_en           = 1'b1;
              wr_word.gen     = next_gen;
              wr_word.refcnt  = RC_W'(1);
              st_we           = 1'b1;
              st_wdata        = SS_BUILDING;
              if (active_q != ACTIVE_MAX) active_d = active_q + 8'd1;
              if (active_d > peak_q) peak_d = active_d;
              res_d.success         = 1'b1;
              res_d.slot_index      = HIDX_W'(idx_q);
              res_d.slot_generation = next_gen;
            end
          end
          FN_PUBLISH, FN_RETAIN, FN_RESOLVE, FN_RELEASE: begin
            priority if (stale) begin
              ev_en        = 1'b1;
              ev_sel       = EV_STALE;
              res_d.status = STS_STALE;
            end else if (func_q == FN_PUBLISH) begin
              ev_en = 1'b1;
              if (cur_st == SS_BUILDING) begin
                ev_sel        = EV_PUBLISH;
                st_we         = 1'b1;
                st_wdata      = SS_PUBLISHED;
                res_d.success = 1'b1;
              end else begin
                ev_sel       = EV_INVALID;
                res_d.status = STS_INVALID;
              end
            end else if (func_q == FN_RETAIN) begin
              ev_en = 1'b1;
              if (cur_st == SS_PUBLISHED && cur_rc != RC_MAX) begin
                ev_sel         = EV_RETAIN;
                wr_en          = 1'b1;
                wr_word.gen    = cur_gen;
                wr_word.refcnt = cur_rc + RC_W'(1);
                res_d.success  = 1'b1;
              end else begin
                ev_sel       = EV_INVALID;
                res_d.status = STS_INVALID;
              end
            end else if (func_q == FN_RESOLVE) begin
              if (cur_st == SS_PUBLISHED) begin
                res_d.success    = 1'b1;
                res_d.slot_index = HIDX_W'(idx_q);
              end else begin
                ev_en        = 1'b1;
                ev_sel       = EV_INVALID;
                res_d.status = STS_INVALID;
              end
            end else begin
              ev_en          = 1'b1;
              ev_sel         = EV_RELEASE;
              wr_en          = 1'b1;
              wr_word.gen    = cur_gen;
              wr_word.refcnt = dec_rc;
              res_d.success  = 1'b1;
              if (dec_rc == '0) begin
                st_we    = 1'b1;
                st_wdata = SS_FREE;
                if (active_q != 8'd0) active_d = active_q - 8'd1;
              end
            end
          end
          FN_RECLAIM: begin
            ev_en         = 1'b1;
            ev_sel        = EV_RECLAIM;
            res_d.success = 1'b1;
          end
          FN_READ_STAT: begin
            priority if (sel_q == STAT_ACTIVE) begin
              res_d.stat_value = GEN_W'(active_q);
              res_d.success    = 1'b1;
            end else if (sel_q == STAT_PEAK) begin
              res_d.stat_value = GEN_W'(peak_q);
              res_d.success    = 1'b1;
            end else if (sel_q <= STAT_LAST) begin
              res_d.stat_value = ev_q[stat_ev];
              res_d.success    = 1'b1;
            end else begin
              res_d.status = STS_INVALID;
            end
          end
          default: begin
            res_d.status = STS_INVALID;
          end
        endcase
      end
      default: begin
        fsm_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q    <= FSM_IDLE;
      full_q   <= 1'b0;
      done_q   <= 1'b0;
      active_q <= '0;
      peak_q   <= '0;
    end else begin
      fsm_q    <= fsm_d;
      full_q   <= full_d;
      done_q   <= done_d;
      active_q <= active_d;
      peak_q   <= peak_d;
    end
  end

  // request payload and result, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    res_q <= res_d;
    if (accept) begin
      func_q <= func_e'(req_i.func);
      gen_q  <= req_i.handle_generation;
      sel_q  <= req_i.stat_select;
      oob_q  <= (req_i.handle_index >= HIDX_W'(SLOT_COUNT));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_vld_q <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) slot_state_q[i] <= SS_FREE;
      for (int i = 0; i < EV_COUNT; i++) ev_q[i] <= '0;
    end else begin
      if (st_we) slot_state_q[idx_q] <= st_wdata;
      if (wr_en) gen_vld_q[idx_q] <= 1'b1;
      if (ev_en && ev_q[ev_sel] != GEN_MAX) ev_q[ev_sel] <= ev_q[ev_sel] + GEN_W'(1);
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) slot_mem[idx_q] <= wr_word;
    rd_q <= slot_mem[rd_addr];
  end

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(fsm_q == FSM_EXEC))
    else $error("result strobe without an executed request");

  a_active_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= peak_q)
    else $error("active slot count above peak");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_gen_only_on_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.slot_generation != '0) |-> res_q.success)
    else $error("generation returned on a failed request");

endmodule

[dv/tb_generation_handle_slot_pool.sv]
module tb_generation_handle_slot_pool;
  timeunit 1ns;
  timeprecision 1ps;

  import ghp_pkg::*;

  localparam int unsigned SLOTS        = 8;
  localparam int unsigned PHASE_ITEMS  = 400;
  localparam logic [2:0]  FN_UNUSED    = 3'd7;

  class pool_ledger;
    slot_state_e      slot_st [SLOTS];
    logic [GEN_W-1:0] gen     [SLOTS];
    logic [RC_W-1:0]  refcnt  [SLOTS];
    logic [7:0]       active;
    logic [7:0]       peak;
    logic [GEN_W-1:0] events  [EV_COUNT];
    res_t             awaited_responses [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      full_refusals;

    function new();
      foreach (slot_st[i]) begin
        slot_st[i] = SS_FREE;
        gen[i]     = '0;
        refcnt[i]  = '0;
      end
      foreach (events[i]) events[i] = '0;
      active        = '0;
      peak          = '0;
      errors        = 0;
      checked       = 0;
      full_refusals = 0;
    endfunction

    function void bump(ev_e which);
      if (events[which] != GEN_MAX) events[which]++;
    endfunction

    function int live_slot(logic [GEN_W-1:0] g, logic [HIDX_W-1:0] idx);
      if (g == '0 || idx >= SLOTS) return -1;
      if (slot_st[idx] == SS_FREE || gen[idx] != g || refcnt[idx] == '0) return -1;
      return int'(idx);
    endfunction

    // Random non-free slot, -1 when the pool is empty.
    function int pick_live();
      int cands [$];
      foreach (slot_st[i]) if (slot_st[i] != SS_FREE) cands.push_back(i);
      if (cands.size() == 0) return -1;
      return cands[$urandom_range(cands.size() - 1, 0)];
    endfunction

    function res_t apply_request(req_t r);
      res_t o;
      int   s;
      o = '0;
      case (r.func)
        FN_ACQUIRE: begin
          s = -1;
          for (int i = SLOTS - 1; i >= 0; i--) if (slot_st[i] == SS_FREE) s = i;
          if (s < 0) begin
            bump(EV_ACQFAIL);
            o.status = STS_FULL;
            full_refusals++;
          end else begin
            gen[s] = gen[s] + 1'b1;
            if (gen[s] == '0) gen[s] = GEN_W'(1);
            refcnt[s]  = RC_W'(1);
            slot_st[s] = SS_BUILDING;
            if (active != ACTIVE_MAX) active++;
            if (active > peak) peak = active;
            bump(EV_ACQUIRE);
            o.success         = 1'b1;
            o.slot_index      = HIDX_W'(s);
            o.slot_generation = gen[s];
          end
        end
        FN_PUBLISH, FN_RETAIN, FN_RESOLVE, FN_RELEASE: begin
          s = live_slot(r.handle_generation, r.handle_index);
          if (s < 0) begin
            bump(EV_STALE);
            o.status = STS_STALE;
          end else begin
            case (r.func)
              FN_PUBLISH: begin
                if (slot_st[s] == SS_BUILDING) begin
                  slot_st[s] = SS_PUBLISHED;
                  bump(EV_PUBLISH);
                  o.success = 1'b1;
                end else begin
                  bump(EV_INVALID);
                  o.status = STS_INVALID;
                end
              end
              FN_RETAIN: begin
                if (slot_st[s] == SS_PUBLISHED && refcnt[s] != RC_MAX) begin
                  refcnt[s]++;
                  bump(EV_RETAIN);
                  o.success = 1'b1;
                end else begin
                  bump(EV_INVALID);
                  o.status = STS_INVALID;
                end
              end
              FN_RESOLVE: begin
                if (slot_st[s] == SS_PUBLISHED) begin
                  o.success    = 1'b1;
                  o.slot_index = r.handle_index;
                end else begin
                  bump(EV_INVALID);
                  o.status = STS_INVALID;
                end
              end
              default: begin
                // building and published slots release alike
                refcnt[s]--;
                if (refcnt[s] == '0) begin
                  slot_st[s] = SS_FREE;
                  if (active != '0) active--;
                end
                bump(EV_RELEASE);
                o.success = 1'b1;
              end
            endcase
          end
        end
        FN_RECLAIM: begin
          bump(EV_RECLAIM);
          o.success = 1'b1;
        end
        FN_READ_STAT: begin
          if (r.stat_select == STAT_ACTIVE) begin
            o.stat_value = GEN_W'(active);
            o.success    = 1'b1;
          end else if (r.stat_select == STAT_PEAK) begin
            o.stat_value = GEN_W'(peak);
            o.success    = 1'b1;
          end else if (r.stat_select <= STAT_LAST) begin
            o.stat_value = events[r.stat_select - STAT_EV_BASE];
            o.success    = 1'b1;
          end else begin
            o.status = STS_INVALID;
          end
        end
        default: o.status = STS_INVALID;
      endcase
      return o;
    endfunction

    function void note_request(req_t r);
      awaited_responses.push_back(apply_request(r));
    endfunction

    function void compare(string field, logic [GEN_W-1:0] exp, logic [GEN_W-1:0] act);
      if (exp !== act) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, exp, act);
        errors++;
      end
    endfunction

    function void check_response(res_t got);
      res_t exp;
      if (awaited_responses.size() == 0) begin
        $error("response with nothing outstanding: 0x%0h", got);
        errors++;
        return;
      end
      exp = awaited_responses.pop_front();
      checked++;
      compare("success", GEN_W'(exp.success), GEN_W'(got.success));
      compare("status", GEN_W'(exp.status), GEN_W'(got.status));
      compare("slot_index", GEN_W'(exp.slot_index), GEN_W'(got.slot_index));
      compare("slot_generation", exp.slot_generation, got.slot_generation);
      compare("stat_value", exp.stat_value, got.stat_value);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  res_t res_o;

  pool_ledger  ledger = new();
  int unsigned n_accepted = 0;
  int unsigned idle_pct   = 0;

  generation_handle_slot_pool #(.SLOT_COUNT(SLOTS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) ledger.check_response(res_o);
      if (start && !busy) begin
        n_accepted++;
        ledger.note_request(req_i);
      end
    end
  end

  function automatic req_t make_req(logic [2:0] f, logic [GEN_W-1:0] g,
                                    logic [HIDX_W-1:0] idx, logic [SEL_W-1:0] sel);
    req_t r;
    r.func              = f;
    r.handle_generation = g;
    r.handle_index      = idx;
    r.stat_select       = sel;
    return r;
  endfunction

  // Call at a falling edge; returns at the falling edge after the request is taken, or later after an idle gap.
  task automatic send_request(input req_t r);
    int unsigned seen;
    seen = n_accepted;
    start <= 1'b1;
    req_i <= r;
    do @(negedge clk_i); while (n_accepted == seen);
    if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
    end
  endtask

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    int          s;
    r.handle_generation = $urandom();
    r.handle_index      = HIDX_W'($urandom_range(255, 0));
    r.stat_select       = SEL_W'($urandom_range(15, 0));
    pick = $urandom_range(99, 0);
    if (pick < 20)      r.func = FN_ACQUIRE;
    else if (pick < 35) r.func = FN_PUBLISH;
    else if (pick < 50) r.func = FN_RETAIN;
    else if (pick < 63) r.func = FN_RESOLVE;
    else if (pick < 83) r.func = FN_RELEASE;
    else if (pick < 86) r.func = FN_RECLAIM;
    else if (pick < 98) r.func = FN_READ_STAT;
    else                r.func = FN_UNUSED;

    if (r.func >= FN_PUBLISH && r.func <= FN_RELEASE) begin
      s = ledger.pick_live();
      if (s >= 0 && $urandom_range(99, 0) < 80) begin
        r.handle_index      = HIDX_W'(s);
        r.handle_generation = ledger.gen[s];
      end else begin
        case ($urandom_range(3, 0))
          0: r.handle_generation = '0;
          1: r.handle_index = HIDX_W'($urandom_range(255, SLOTS));
          2: begin
            // current or one-lower generation on an in-range index
            r.handle_index      = HIDX_W'($urandom_range(SLOTS - 1, 0));
            r.handle_generation = ledger.gen[r.handle_index] - $urandom_range(1, 0);
          end
          default: ;
        endcase
      end
    end
    if (r.func == FN_READ_STAT && $urandom_range(99, 0) < 85)
      r.stat_select = SEL_W'($urandom_range(STAT_LAST, 0));
    return r;
  endfunction

  task automatic run_directed();
    send_request(make_req(FN_RESOLVE, '0, 8'd0, '0));
    send_request(make_req(FN_PUBLISH, 32'd1, 8'd0, '0));
    send_request(make_req(FN_ACQUIRE, GEN_MAX, 8'hFF, 4'hF));
    send_request(make_req(FN_RESOLVE, 32'd1, 8'd0, '0));
    send_request(make_req(FN_RETAIN, 32'd1, 8'd0, '0));
    send_request(make_req(FN_PUBLISH, 32'd1, 8'd0, '0));
    send_request(make_req(FN_PUBLISH, 32'd1, 8'd0, '0));
    send_request(make_req(FN_RETAIN, 32'd1, 8'd0, '0));
    send_request(make_req(FN_RESOLVE, 32'd1, 8'd0, '0));
    send_request(make_req(FN_RESOLVE, GEN_MAX, 8'hFF, '0));
    send_request(make_req(FN_RESOLVE, 32'd2, 8'd0, '0));
    send_request(make_req(FN_ACQUIRE, '0, 8'd0, '0));
    send_request(make_req(FN_RELEASE, 32'd1, 8'd1, '0));
    repeat (SLOTS - 1) send_request(make_req(FN_ACQUIRE, '0, 8'd0, '0));
    send_request(make_req(FN_ACQUIRE, '0, 8'd0, '0));
    send_request(make_req(FN_RECLAIM, GEN_MAX, 8'hFF, 4'hF));
    send_request(make_req(FN_UNUSED, GEN_MAX, 8'hFF, 4'hF));
    send_request(make_req(FN_READ_STAT, '0, 8'd0, 4'hF));
    send_request(make_req(FN_READ_STAT, '0, 8'd0, STAT_LAST + 1'b1));
    send_request(make_req(FN_READ_STAT, '0, 8'd0, STAT_LAST));
  endtask

  // Walk one live slot through publish (when still building), an extra retain, resolve and release.
  task automatic run_slot_lifecycle();
    int s;
    s = ledger.pick_live();
    if (s < 0) begin
      send_request(make_req(FN_ACQUIRE, '0, 8'd0, '0));
      s = ledger.pick_live();
    end
    if (ledger.slot_st[s] == SS_BUILDING)
      send_request(make_req(FN_PUBLISH, ledger.gen[s], HIDX_W'(s), '0));
    send_request(make_req(FN_RETAIN, ledger.gen[s], HIDX_W'(s), '0));
    send_request(make_req(FN_RESOLVE, ledger.gen[s], HIDX_W'(s), '0));
    send_request(make_req(FN_RELEASE, ledger.gen[s], HIDX_W'(s), '0));
    send_request(make_req(FN_READ_STAT, '0, 8'd0, STAT_EV_BASE + EV_RETAIN));
  endtask

  initial begin
    int unsigned mixes [3];
    int unsigned drain;
    mixes = '{0, 60, 15};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    foreach (mixes[m]) begin
      idle_pct = mixes[m];
      repeat (PHASE_ITEMS) send_request(random_request());
    end
    idle_pct = 0;
    run_slot_lifecycle();
    start <= 1'b0;

    drain = 0;
    while (ledger.awaited_responses.size() != 0 && drain < 200) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (20) @(negedge clk_i);
    if (ledger.awaited_responses.size() != 0) begin
      $error("%0d responses never arrived", ledger.awaited_responses.size());
      ledger.errors++;
    end

    $display("Checked %0d responses for %0d requests: directed cases, three idle mixes,",
             ledger.checked, n_accepted);
    $display("  %0d pool-full refusals along the way.", ledger.full_refusals);
    if (ledger.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
